// ===== design/text_console_character_engine_assert.svh =====
// Assertion macros shared by the text console engine checker.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define TCCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define TCCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tcce_pkg.sv =====
// Shared types, codes and helpers for the text console character engine.
// No dependencies; used by the top level and by its checker.
package tcce_pkg;

    // Cell layout: background [15:12], foreground [11:8], character [7:0].
    localparam int CELL_W = 16;

    // Control characters handled by the terminal write.
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BLANK     = 8'h00;

    // Color registers after reset.
    localparam logic [3:0] RESET_BG = 4'h0;
    localparam logic [3:0] RESET_FG = 4'h7;

    // Configuration register indexes.
    localparam logic CFG_BACKGROUND = 1'b0;
    localparam logic CFG_FOREGROUND = 1'b1;

    typedef enum logic [2:0] {
        OP_PUTC       = 3'd0,
        OP_PUT_AT     = 3'd1,
        OP_SET_CHAR   = 3'd2,
        OP_SET_CURSOR = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_READ       = 3'd5
    } t_opcode;

    // Packs colors and character into one cell.
    function automatic logic [CELL_W-1:0] make_cell(input logic [3:0] bg,
                                                    input logic [3:0] fg,
                                                    input logic [7:0] ch);
        make_cell = {bg, fg, ch};
    endfunction

endpackage

// ===== design/text_console_character_engine.sv =====
// Text console character engine: screen cell store, cursor and terminal writes.
// Depends on tcce_pkg and tcce_ram; a sequencer drives one cell RAM port pair.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------
//   in      | input     | i_in_valid / o_in_stall | opcode, char, column, row, colors
//   out     | output    | o_out_valid/i_out_stall | cursor column, cursor row, cell
//   cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_wdata
//
// A result is registered as its item leaves S_DONE, after S_EXEC and, for a cell read or a
// backspace, S_RDATA or S_BS_WRITE; the input takes the next item once it is registered.
// A scroll copies every cell up one row through the RAM read port, then blanks the
// bottom row; a clear blanks the whole store, and a tab writes TAB_WIDTH blanks
// plus any scroll it causes: one RAM write port sets the pace.
// After reset the cell RAM is swept to blank cells in the reset colors, one cell
// per cycle with the input stalled.
// A finished result waits in the output register while the next item is taken.
module text_console_character_engine #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [3:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_in_opcode,
    input  logic [7:0] i_in_char_code,
    input  logic [6:0] i_in_column,
    input  logic [4:0] i_in_row,
    input  logic [3:0] i_in_cell_background,
    input  logic [3:0] i_in_cell_foreground,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_out_cursor_column,
    output logic [4:0] o_out_cursor_row,
    output logic [15:0] o_out_cell_value
);
    import tcce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CXW   = $clog2(COLUMNS);
    localparam int CYW   = $clog2(ROWS);
    localparam int TW    = $clog2(TAB_WIDTH + 1);

    localparam logic [AW-1:0]  COLS_A      = AW'(COLUMNS);
    localparam logic [AW-1:0]  LAST_CELL   = AW'(CELLS - 1);
    localparam logic [AW-1:0]  LAST_ROW_A  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0]  LAST_COPY   = AW'(CELLS - COLUMNS - 1);
    localparam logic [CXW-1:0] LAST_COL    = CXW'(COLUMNS - 1);
    localparam logic [CYW-1:0] LAST_ROW    = CYW'(ROWS - 1);
    localparam logic [7:0]     COL_LIMIT   = 8'(COLUMNS);
    localparam logic [5:0]     ROW_LIMIT   = 6'(ROWS);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_BS_WRITE,
        S_TAB,
        S_SCROLL,
        S_DRAIN,
        S_BLANK,
        S_RDATA,
        S_DONE
    } t_state;

    // Control registers.
    t_state          r_state, n_state;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic            r_pend, n_pend;
    logic [TW-1:0]   r_tab_left, n_tab_left;
    logic [CXW-1:0]  r_cx, n_cx;
    logic [CYW-1:0]  r_cy, n_cy;
    logic [3:0]      r_bg, n_bg;
    logic [3:0]      r_fg, n_fg;
    logic            r_out_valid, n_out_valid;

    // Payload registers.
    logic [AW-1:0]       r_pend_addr, n_pend_addr;
    t_opcode             r_op, n_op;
    logic [7:0]          r_ch, n_ch;
    logic [CXW-1:0]      r_col, n_col;
    logic [CYW-1:0]      r_row, n_row;
    logic [2:0]          r_item_bg, n_item_bg;
    logic [3:0]          r_item_fg, n_item_fg;
    logic [CELL_W-1:0]   r_cell, n_cell;
    logic [6:0]          r_out_col, n_out_col;
    logic [4:0]          r_out_row, n_out_row;
    logic [CELL_W-1:0]   r_out_cell, n_out_cell;

    // RAM port signals.
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    // Shared address unit and helpers.
    logic              use_item_pos;
    logic [CXW-1:0]    addr_col, in_col_sat;
    logic [CYW-1:0]    addr_row, in_row_sat;
    logic [AW-1:0]     cell_addr;
    logic              at_last_row;
    logic [CELL_W-1:0] putc_blank, full_blank;

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Saturate the incoming position to the last column and row.
    assign in_col_sat = ({1'b0, i_in_column} >= COL_LIMIT) ? LAST_COL : CXW'(i_in_column);
    assign in_row_sat = ({1'b0, i_in_row} >= ROW_LIMIT) ? LAST_ROW : CYW'(i_in_row);

    // One multiply-add turns either the cursor or the item position into a cell address.
    assign use_item_pos = (r_state == S_EXEC) && ((r_op == OP_PUT_AT) || (r_op == OP_READ));
    assign addr_col     = use_item_pos ? r_col : r_cx;
    assign addr_row     = use_item_pos ? r_row : r_cy;
    assign cell_addr    = AW'(addr_row) * COLS_A + AW'(addr_col);

    assign at_last_row = (r_cy == LAST_ROW);
    assign putc_blank  = make_cell({1'b0, r_bg[2:0]}, r_fg, CH_BLANK);
    assign full_blank  = make_cell(r_bg, r_fg, CH_BLANK);

    // Sequencer: next state, cursor, and RAM port control.
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_tab_left  = r_tab_left;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_bg        = r_bg;
        n_fg        = r_fg;
        n_op        = r_op;
        n_ch        = r_ch;
        n_col       = r_col;
        n_row       = r_row;
        n_item_bg   = r_item_bg;
        n_item_fg   = r_item_fg;
        n_cell      = r_cell;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_cell  = r_out_cell;
        n_out_valid = r_out_valid && i_out_stall;

        ram_we    = 1'b0;
        ram_waddr = cell_addr;
        ram_wdata = full_blank;
        ram_re    = 1'b0;
        ram_raddr = cell_addr;

        // Color registers are written whenever the port asks.
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BACKGROUND: n_bg = i_cfg_wdata;
                CFG_FOREGROUND: n_fg = i_cfg_wdata;
                default: ;
            endcase
        end

        case (r_state)
            // Sweep the whole store to blank cells in the reset colors.
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr;
                ram_wdata = make_cell(RESET_BG, RESET_FG, CH_BLANK);
                n_ptr     = AW'(r_ptr + 1'b1);
                if (r_ptr == LAST_CELL) begin
                    n_state = S_IDLE;
                end
            end

            // Take an item in and hold its fields.
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = t_opcode'(i_in_opcode);
                    n_ch       = i_in_char_code;
                    n_col      = in_col_sat;
                    n_row      = in_row_sat;
                    n_item_bg  = i_in_cell_background[2:0];
                    n_item_fg  = i_in_cell_foreground;
                    n_cell     = '0;
                    n_tab_left = '0;
                    n_state    = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_DONE;
                case (r_op)
                    OP_PUTC: begin
                        case (r_ch)
                            CH_BACKSPACE: begin
                                if (r_cx == '0) begin
                                    n_cx = LAST_COL;
                                    if (r_cy != '0) begin
                                        n_cy = CYW'(r_cy - 1'b1);
                                    end
                                end else begin
                                    n_cx = CXW'(r_cx - 1'b1);
                                end
                                n_state = S_BS_WRITE;
                            end
                            CH_NEWLINE: begin
                                n_cx = '0;
                                if (at_last_row) begin
                                    n_ptr   = '0;
                                    n_pend  = 1'b0;
                                    n_state = S_SCROLL;
                                end else begin
                                    n_cy = CYW'(r_cy + 1'b1);
                                end
                            end
                            CH_TAB: begin
                                n_tab_left = TW'(TAB_WIDTH);
                                n_state    = S_TAB;
                            end
                            CH_RETURN: begin
                                n_cx = '0;
                            end
                            default: begin
                                // Ordinary character: write, then advance.
                                ram_we    = 1'b1;
                                ram_wdata = make_cell({1'b0, r_bg[2:0]}, r_fg, r_ch);
                                if (r_cx == LAST_COL) begin
                                    n_cx = '0;
                                    if (at_last_row) begin
                                        n_ptr   = '0;
                                        n_pend  = 1'b0;
                                        n_state = S_SCROLL;
                                    end else begin
                                        n_cy = CYW'(r_cy + 1'b1);
                                    end
                                end else begin
                                    n_cx = CXW'(r_cx + 1'b1);
                                end
                            end
                        endcase
                    end
                    OP_PUT_AT: begin
                        ram_we    = 1'b1;
                        ram_wdata = make_cell({1'b0, r_item_bg}, r_item_fg, r_ch);
                    end
                    OP_SET_CHAR: begin
                        ram_we    = 1'b1;
                        ram_wdata = make_cell(r_bg, r_fg, r_ch);
                    end
                    OP_SET_CURSOR: begin
                        n_cx = r_col;
                        n_cy = r_row;
                    end
                    OP_CLEAR: begin
                        n_cx    = '0;
                        n_cy    = '0;
                        n_ptr   = '0;
                        n_state = S_BLANK;
                    end
                    OP_READ: begin
                        ram_re  = 1'b1;
                        n_state = S_RDATA;
                    end
                    default: ;
                endcase
            end

            // Blank the cell under the cursor after a backspace.
            S_BS_WRITE: begin
                ram_we    = 1'b1;
                ram_wdata = putc_blank;
                n_state   = S_DONE;
            end

            // One tab blank per cycle, each followed by an advance, unless a scroll holds them.
            S_TAB: begin
                ram_we     = 1'b1;
                ram_wdata  = putc_blank;
                n_tab_left = TW'(r_tab_left - 1'b1);
                n_state    = (r_tab_left == TW'(1)) ? S_DONE : S_TAB;
                if (r_cx == LAST_COL) begin
                    n_cx = '0;
                    if (at_last_row) begin
                        n_ptr   = '0;
                        n_pend  = 1'b0;
                        n_state = S_SCROLL;
                    end else begin
                        n_cy = CYW'(r_cy + 1'b1);
                    end
                end else begin
                    n_cx = CXW'(r_cx + 1'b1);
                end
            end

            // Copy each cell up one row: read one row below, write once the registered read returns.
            S_SCROLL: begin
                ram_re      = 1'b1;
                ram_raddr   = AW'(r_ptr + COLS_A);
                n_pend      = 1'b1;
                n_pend_addr = r_ptr;
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_addr;
                    ram_wdata = ram_rdata;
                end
                if (r_ptr == LAST_COPY) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = AW'(r_ptr + 1'b1);
                end
            end

            // Write the last copied cell, then blank the bottom row.
            S_DRAIN: begin
                ram_we    = 1'b1;
                ram_waddr = r_pend_addr;
                ram_wdata = ram_rdata;
                n_pend    = 1'b0;
                n_ptr     = LAST_ROW_A;
                n_state   = S_BLANK;
            end

            // Blank fill to the end of the store, for scroll and clear.
            S_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr;
                ram_wdata = full_blank;
                if (r_ptr == LAST_CELL) begin
                    n_state = (r_tab_left != '0) ? S_TAB : S_DONE;
                end else begin
                    n_ptr = AW'(r_ptr + 1'b1);
                end
            end

            S_RDATA: begin
                n_cell  = ram_rdata;
                n_state = S_DONE;
            end

            // Load the output register once it is free.
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_col   = 7'(r_cx);
                    n_out_row   = 5'(r_cy);
                    n_out_cell  = r_cell;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State, cursor, configuration and output registers.
    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_op        <= n_op;
        r_ch        <= n_ch;
        r_col       <= n_col;
        r_row       <= n_row;
        r_item_bg   <= n_item_bg;
        r_item_fg   <= n_item_fg;
        r_cell      <= n_cell;
        r_out_col   <= n_out_col;
        r_out_row   <= n_out_row;
        r_out_cell  <= n_out_cell;
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_tab_left  <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_bg        <= RESET_BG;
            r_fg        <= RESET_FG;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_pend      <= n_pend;
            r_tab_left  <= n_tab_left;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_bg        <= n_bg;
            r_fg        <= n_fg;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall          = (r_state != S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_out_cursor_column = r_out_col;
    assign o_out_cursor_row    = r_out_row;
    assign o_out_cell_value    = r_out_cell;

endmodule

// ===== design/tcce_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; holds the screen cells of the console engine.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tcce_checker.sv =====
// Port-level checker for the text console character engine, bound to the top level.
// Depends on tcce_pkg and the assertion macros in text_console_character_engine_assert.svh.
`include "text_console_character_engine_assert.svh"

module tcce_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [2:0] i_in_opcode,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [6:0] o_out_cursor_column,
    input logic [4:0] o_out_cursor_row,
    input logic [15:0] o_out_cell_value
);
    import tcce_pkg::*;

    localparam logic [7:0] COL_LIMIT = 8'(COLUMNS);
    localparam logic [5:0] ROW_LIMIT = 6'(ROWS);

    logic    in_xfer;
    logic    out_new;
    logic    r_out_free;
    t_opcode r_op_q;

    assign in_xfer = i_in_valid && !o_in_stall;
    assign out_new = o_out_valid && r_out_free;

    // Opcode of the item in flight, and whether the output register could load last cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_q     <= OP_PUTC;
            r_out_free <= 1'b1;
        end else begin
            r_out_free <= !o_out_valid || !i_out_stall;
            if (in_xfer) begin
                r_op_q <= t_opcode'(i_in_opcode);
            end
        end
    end

    // A result waiting under stall keeps its valid and its payload.
    `TCCE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
                      o_out_valid && $stable(o_out_cell_value) && $stable(o_out_cursor_column)
                      && $stable(o_out_cursor_row), "result changed while stalled")

    // Items are worked one at a time: the input stalls right after a transfer.
    `TCCE_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, in_xfer, o_in_stall,
                      "input not stalled after a transfer")

    // The reported cursor always lies on the screen.
    `TCCE_ASSERT_NOW(a_cursor_range, i_clk, i_rst_n, o_out_valid,
                     (8'(o_out_cursor_column) < COL_LIMIT) && (6'(o_out_cursor_row) < ROW_LIMIT),
                     "cursor off screen")

    // Only a cell read reports a nonzero cell value.
    `TCCE_ASSERT_NOW(a_cell_zero, i_clk, i_rst_n, out_new && (r_op_q != OP_READ),
                     o_out_cell_value == 16'h0000, "cell value set for a non-read item")

endmodule

bind text_console_character_engine tcce_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcce_checker (.*);
